@@ rtl/hnmg_pkg.sv @@
// ----------------------------------------------------------------------------
// hnmg_pkg
// shared sizes, codes and types of the height map to normal map generator
// ----------------------------------------------------------------------------
package hnmg_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH = 3 * MAX_WIDTH;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);

    // configuration
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIM_W      = 11;
    localparam int SHARP_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARPNESS    = 2'd2;

    localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 11'd1024;
    localparam logic [SHARP_W-1:0] RST_SHARPNESS    = 16'd1000;

    // stream payloads
    localparam int H_W      = 16;
    localparam int N_W      = 16;
    localparam int POS_W    = 10;
    localparam int I_DATA_W = 16;
    localparam int O_DATA_W = 72;

    // arithmetic: X = 125*dx, Y = 8192*sharpness, Z = 125*dz
    localparam int X_SCALE  = 125;
    localparam int Y_SHIFT  = 13;
    localparam int MAGX_W   = 23;
    localparam int MB_W     = 23;
    localparam int S_W      = 59;
    localparam int ROOT_TOP = S_W - 1;
    localparam int L_W      = 30;
    localparam int NUM_W    = 46;
    localparam int Q_W      = 16;
    localparam int CNT_W    = $clog2(Q_W);

    localparam logic [N_W-1:0] HALF = 16'h8000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_PREP,
        ST_SQ_LD,
        ST_SQ,
        ST_ROOT,
        ST_DIV_LD,
        ST_DIV,
        ST_FIN
    } t_state;

    // which neighbor set a result uses
    typedef enum logic [1:0] {
        K_BELOW = 2'd0,
        K_LEFT  = 2'd1,
        K_LAST  = 2'd2
    } t_kind;

endpackage

@@ rtl/heightmap_normal_map_generator_unit.sv @@
// ----------------------------------------------------------------------------
// heightmap_normal_map_generator_unit
// central difference normal map from a raster stream of Q0.16 heights
// ----------------------------------------------------------------------------
// channel    dir  payload                                           last / user
// s_axis     in   height_sample[15:0]                               -    / -
// m_axis     out  normal_x, normal_y, normal_z, column, row         run  / image end
// i_cfg_*    in   index 0 width, 1 height, 2 sharpness              -    / -
//
// one item is in flight at a time; tready is high only while idle
// each result passes through three read states, a prep state, a shift-add
// squarer over |X|, sharpness and |Z|, a bit-pair root, three restoring
// divides and an output state; an item yields 0 to 3 results, and a zero
// vector skips the math
// a waiting result sits in the output register, the next item is taken meanwhile
// synchronous active-low reset; line memory contents are not cleared
// ----------------------------------------------------------------------------
module heightmap_normal_map_generator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [hnmg_pkg::I_DATA_W-1:0]  s_axis_tdata,   // height_sample
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // normal_x, normal_y, normal_z, pixel_column, pixel_row, zero fill
    output logic [hnmg_pkg::O_DATA_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tlast,   // run_last
    output logic                           m_axis_tuser,   // image_last
    input  logic                           i_cfg_we,
    input  logic [hnmg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hnmg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hnmg_pkg::*;

    function automatic logic [1:0] line_prev(input logic [1:0] line);
        return (line == 2'd0) ? 2'd2 : line - 2'd1;
    endfunction

    function automatic logic [1:0] line_next(input logic [1:0] line);
        return (line == 2'd2) ? 2'd0 : line + 2'd1;
    endfunction

    function automatic logic [ADDR_W-1:0] line_addr(input logic [1:0] line,
                                                     input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        case (line)
            2'd0:    base = '0;
            2'd1:    base = ADDR_W'(MAX_WIDTH);
            default: base = ADDR_W'(2 * MAX_WIDTH);
        endcase
        return base + ADDR_W'(col);
    endfunction

    function automatic t_kind pick_kind(input logic [2:0] pend);
        if (pend[0]) begin
            return K_BELOW;
        end else if (pend[1]) begin
            return K_LEFT;
        end
        return K_LAST;
    endfunction

    // 32768 +/- t, saturated at the top
    function automatic logic [N_W-1:0] map_half(input logic [Q_W-1:0] q, input logic neg);
        logic [N_W:0] sum;
        sum = {1'b0, HALF} + (N_W+1)'(q);
        if (neg) begin
            return HALF - N_W'(q);
        end else if (sum[N_W]) begin
            return '1;
        end
        return sum[N_W-1:0];
    endfunction

    // control
    t_state               r_state, n_state;
    logic [DIM_W-1:0]     r_width, n_width;
    logic [DIM_W-1:0]     r_height, n_height;
    logic [SHARP_W-1:0]   r_sharp, n_sharp;
    logic [COL_W-1:0]     r_col, n_col;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [1:0]           r_rot, n_rot;
    logic                 r_ovalid, n_ovalid;

    // current item
    logic [H_W-1:0]       r_sample, n_sample;
    logic [COL_W-1:0]     r_c, n_c;
    logic [ROW_W-1:0]     r_r, n_r;
    logic [1:0]           r_cur, n_cur;
    logic [COL_W-1:0]     r_wl, n_wl;
    logic [ROW_W-1:0]     r_hl, n_hl;
    logic [2:0]           r_pend, n_pend;
    t_kind                r_kind, n_kind;

    // datapath
    logic [H_W-1:0]       r_left, n_left;
    logic [H_W-1:0]       r_right, n_right;
    logic [H_W-1:0]       r_adx, n_adx;
    logic [H_W-1:0]       r_adz, n_adz;
    logic                 r_sx, n_sx;
    logic                 r_sz, n_sz;
    logic [MAGX_W-1:0]    r_mag_x, n_mag_x;
    logic [MAGX_W-1:0]    r_mag_z, n_mag_z;
    logic [1:0]           r_j, n_j;
    logic [S_W-1:0]       r_acc, n_acc;
    logic [S_W-1:0]       r_ma, n_ma;
    logic [MB_W-1:0]      r_mb, n_mb;
    logic [S_W-1:0]       r_res, n_res;
    logic [S_W-1:0]       r_bit, n_bit;
    logic [L_W-1:0]       r_len, n_len;
    logic [NUM_W-1:0]     r_rem, n_rem;
    logic [NUM_W-1:0]     r_den, n_den;
    logic [Q_W-1:0]       r_q, n_q;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [N_W-1:0]       r_nx, n_nx;
    logic [N_W-1:0]       r_ny, n_ny;
    logic [N_W-1:0]       r_nz, n_nz;

    // output register
    logic [O_DATA_W-1:0]  r_o_data, n_o_data;
    logic                 r_o_last, n_o_last;
    logic                 r_o_user, n_o_user;

    // line memory
    logic [H_W-1:0]       r_row_lines [LINE_DEPTH];
    logic [H_W-1:0]       r_rd0;
    logic [H_W-1:0]       r_rd1;

    logic [COL_W-1:0]     w_wl, w_csat, w_cm1, w_cp1, w_cx, w_cxm1, w_pcol;
    logic [ROW_W-1:0]     w_hl, w_rsat, w_prow;
    logic [1:0]           w_prev, w_next;
    logic [ADDR_W-1:0]    w_a0, w_a1, w_a2, w_a3;
    logic [ADDR_W-1:0]    w_raddr0, w_raddr1, w_waddr;
    logic                 w_mem_we;
    logic [S_W:0]         w_trial;
    logic                 w_ge;
    logic [Q_W-1:0]       w_q_next;
    logic [NUM_W-1:0]     w_div_mag;
    logic                 w_div_neg;
    logic [N_W-1:0]       w_map;
    logic [2:0]           w_flags;
    logic [2:0]           w_pend_rest;

    // effective image size, zero counts as one, large values clamp
    always_comb begin
        if (r_width == '0) begin
            w_wl = '0;
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_wl = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_wl = COL_W'(r_width - 11'd1);
        end
        if (r_height == '0) begin
            w_hl = '0;
        end else if (int'(r_height) > MAX_HEIGHT) begin
            w_hl = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            w_hl = ROW_W'(r_height - 11'd1);
        end
        w_csat = (r_col > w_wl) ? w_wl : r_col;
        w_rsat = (r_row > w_hl) ? w_hl : r_row;
    end

    // neighbor addresses of the current result
    always_comb begin
        w_prev = line_prev(r_cur);
        w_next = line_next(r_cur);
        w_cm1  = (r_c != '0) ? COL_W'(r_c - 1'b1) : '0;
        w_cp1  = (r_c < r_wl) ? COL_W'(r_c + 1'b1) : r_wl;
        w_cx   = COL_W'(r_c - 1'b1);
        w_cxm1 = (w_cx != '0) ? COL_W'(w_cx - 1'b1) : '0;
        case (r_kind)
            K_BELOW: begin
                w_a0 = line_addr(w_prev, w_cm1);
                w_a1 = line_addr(w_prev, w_cp1);
                w_a2 = line_addr((r_r > ROW_W'(1)) ? w_next : w_prev, r_c);
                w_a3 = line_addr(r_cur, r_c);
            end
            K_LEFT: begin
                w_a0 = line_addr(r_cur, w_cxm1);
                w_a1 = line_addr(r_cur, r_c);
                w_a2 = line_addr((r_r != '0) ? w_prev : r_cur, w_cx);
                w_a3 = line_addr(r_cur, w_cx);
            end
            default: begin
                w_a0 = line_addr(r_cur, w_cm1);
                w_a1 = line_addr(r_cur, r_c);
                w_a2 = line_addr((r_r != '0) ? w_prev : r_cur, r_c);
                w_a3 = line_addr(r_cur, r_c);
            end
        endcase
        w_raddr0 = (r_state == ST_RD_B) ? w_a2 : w_a0;
        w_raddr1 = (r_state == ST_RD_B) ? w_a3 : w_a1;
        w_waddr  = line_addr(r_cur, r_c);
        w_mem_we = (r_state == ST_WRITE);
        w_pcol   = (r_kind == K_LEFT) ? w_cx : r_c;
        w_prow   = (r_kind == K_BELOW) ? ROW_W'(r_r - 1'b1) : r_r;
    end

    // iteration arithmetic
    always_comb begin
        w_trial  = {1'b0, r_res} + {1'b0, r_bit};
        w_ge     = (r_rem >= r_den);
        w_q_next = {r_q[Q_W-2:0], w_ge};
        case (r_j)
            2'd0: begin
                w_div_mag = NUM_W'(r_mag_x);
                w_div_neg = r_sx;
            end
            2'd1: begin
                w_div_mag = NUM_W'(r_sharp) << Y_SHIFT;
                w_div_neg = 1'b0;
            end
            default: begin
                w_div_mag = NUM_W'(r_mag_z);
                w_div_neg = r_sz;
            end
        endcase
        w_map = map_half(w_q_next, w_div_neg);
        w_flags[0] = (r_r != '0);
        w_flags[1] = (r_r == r_hl) && (r_c != '0);
        w_flags[2] = (r_r == r_hl) && (r_c == r_wl);
        w_pend_rest = r_pend;
        w_pend_rest[pick_kind(r_pend)] = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_width  = r_width;
        n_height = r_height;
        n_sharp  = r_sharp;
        n_col    = r_col;
        n_row    = r_row;
        n_rot    = r_rot;
        n_ovalid = r_ovalid;
        n_sample = r_sample;
        n_c      = r_c;
        n_r      = r_r;
        n_cur    = r_cur;
        n_wl     = r_wl;
        n_hl     = r_hl;
        n_pend   = r_pend;
        n_kind   = r_kind;
        n_left   = r_left;
        n_right  = r_right;
        n_adx    = r_adx;
        n_adz    = r_adz;
        n_sx     = r_sx;
        n_sz     = r_sz;
        n_mag_x  = r_mag_x;
        n_mag_z  = r_mag_z;
        n_j      = r_j;
        n_acc    = r_acc;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_res    = r_res;
        n_bit    = r_bit;
        n_len    = r_len;
        n_rem    = r_rem;
        n_den    = r_den;
        n_q      = r_q;
        n_cnt    = r_cnt;
        n_nx     = r_nx;
        n_ny     = r_ny;
        n_nz     = r_nz;
        n_o_data = r_o_data;
        n_o_last = r_o_last;
        n_o_user = r_o_user;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  n_width  = i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: n_height = i_cfg_data[DIM_W-1:0];
                CFG_SHARPNESS:    n_sharp  = i_cfg_data[SHARP_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_sample = s_axis_tdata[H_W-1:0];
                    n_c      = w_csat;
                    n_r      = w_rsat;
                    n_cur    = r_rot;
                    n_wl     = w_wl;
                    n_hl     = w_hl;
                    if (w_csat == w_wl) begin
                        n_col = '0;
                        if (w_rsat == w_hl) begin
                            n_row = '0;
                            n_rot = 2'd0;
                        end else begin
                            n_row = ROW_W'(w_rsat + 1'b1);
                            n_rot = line_next(r_rot);
                        end
                    end else begin
                        n_col = COL_W'(w_csat + 1'b1);
                    end
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (w_flags == 3'b000) begin
                    n_state = ST_IDLE;
                end else begin
                    n_kind  = pick_kind(w_flags);
                    n_pend  = w_flags;
                    n_pend[pick_kind(w_flags)] = 1'b0;
                    n_state = ST_RD_A;
                end
            end
            ST_RD_A: begin
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                n_left  = r_rd0;
                n_right = r_rd1;
                n_state = ST_RD_C;
            end
            ST_RD_C: begin
                // dx = left - right, dz = up - down
                n_sx    = (r_left < r_right);
                n_adx   = n_sx ? r_right - r_left : r_left - r_right;
                n_sz    = (r_rd0 < r_rd1);
                n_adz   = n_sz ? r_rd1 - r_rd0 : r_rd0 - r_rd1;
                n_state = ST_PREP;
            end
            ST_PREP: begin
                n_mag_x = MAGX_W'(MAGX_W'(r_adx) * MAGX_W'(X_SCALE));
                n_mag_z = MAGX_W'(MAGX_W'(r_adz) * MAGX_W'(X_SCALE));
                if (r_adx == '0 && r_adz == '0 && r_sharp == '0) begin
                    n_nx    = HALF;
                    n_ny    = HALF;
                    n_nz    = HALF;
                    n_state = ST_FIN;
                end else begin
                    n_acc   = '0;
                    n_j     = 2'd0;
                    n_state = ST_SQ_LD;
                end
            end
            ST_SQ_LD: begin
                case (r_j)
                    2'd0: begin
                        n_ma = S_W'(r_mag_x);
                        n_mb = MB_W'(r_mag_x);
                    end
                    2'd1: begin
                        n_ma = S_W'(r_sharp) << (2 * Y_SHIFT);
                        n_mb = MB_W'(r_sharp);
                    end
                    default: begin
                        n_ma = S_W'(r_mag_z);
                        n_mb = MB_W'(r_mag_z);
                    end
                endcase
                n_state = ST_SQ;
            end
            ST_SQ: begin
                // shift-add square, multiplier bits taken lsb first
                if (r_mb == '0) begin
                    if (r_j == 2'd2) begin
                        n_res   = '0;
                        n_bit   = S_W'(1) << ROOT_TOP;
                        n_state = ST_ROOT;
                    end else begin
                        n_j     = r_j + 2'd1;
                        n_state = ST_SQ_LD;
                    end
                end else begin
                    if (r_mb[0]) begin
                        n_acc = r_acc + r_ma;
                    end
                    n_ma = r_ma << 1;
                    n_mb = r_mb >> 1;
                end
            end
            ST_ROOT: begin
                // one result bit per cycle, remainder kept in the accumulator
                if (r_bit == '0) begin
                    n_len   = L_W'(r_res);
                    n_j     = 2'd0;
                    n_state = ST_DIV_LD;
                end else begin
                    if ({1'b0, r_acc} >= w_trial) begin
                        n_acc = r_acc - S_W'(w_trial);
                        n_res = (r_res >> 1) + r_bit;
                    end else begin
                        n_res = r_res >> 1;
                    end
                    n_bit = r_bit >> 2;
                end
            end
            ST_DIV_LD: begin
                // t = (65536*mag + len) / (2*len)
                n_rem   = (w_div_mag << 16) + NUM_W'(r_len);
                n_den   = NUM_W'(r_len) << 16;
                n_q     = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (w_ge) begin
                    n_rem = r_rem - r_den;
                end
                n_den = r_den >> 1;
                n_q   = w_q_next;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    case (r_j)
                        2'd0:    n_nx = w_map;
                        2'd1:    n_ny = w_map;
                        default: n_nz = w_map;
                    endcase
                    if (r_j == 2'd2) begin
                        n_state = ST_FIN;
                    end else begin
                        n_j     = r_j + 2'd1;
                        n_state = ST_DIV_LD;
                    end
                end
            end
            ST_FIN: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_o_data = {(O_DATA_W - 3 * N_W - 2 * POS_W)'(0),
                                POS_W'(w_prow), POS_W'(w_pcol), r_nz, r_ny, r_nx};
                    n_o_last = (r_pend == 3'b000);
                    n_o_user = (r_kind == K_LAST);
                    n_ovalid = 1'b1;
                    if (r_pend == 3'b000) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_kind  = pick_kind(r_pend);
                        n_pend  = w_pend_rest;
                        n_state = ST_RD_A;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
            r_sharp  <= RST_SHARPNESS;
            r_col    <= '0;
            r_row    <= '0;
            r_rot    <= 2'd0;
            r_ovalid <= 1'b0;
            r_pend   <= 3'b000;
            r_kind   <= K_BELOW;
            r_j      <= 2'd0;
            r_cnt    <= '0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_sharp  <= n_sharp;
            r_col    <= n_col;
            r_row    <= n_row;
            r_rot    <= n_rot;
            r_ovalid <= n_ovalid;
            r_pend   <= n_pend;
            r_kind   <= n_kind;
            r_j      <= n_j;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_c      <= n_c;
        r_r      <= n_r;
        r_cur    <= n_cur;
        r_wl     <= n_wl;
        r_hl     <= n_hl;
        r_left   <= n_left;
        r_right  <= n_right;
        r_adx    <= n_adx;
        r_adz    <= n_adz;
        r_sx     <= n_sx;
        r_sz     <= n_sz;
        r_mag_x  <= n_mag_x;
        r_mag_z  <= n_mag_z;
        r_acc    <= n_acc;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_res    <= n_res;
        r_bit    <= n_bit;
        r_len    <= n_len;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_q      <= n_q;
        r_nx     <= n_nx;
        r_ny     <= n_ny;
        r_nz     <= n_nz;
        r_o_data <= n_o_data;
        r_o_last <= n_o_last;
        r_o_user <= n_o_user;
    end

    // three row lines, one write port and two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_row_lines[w_waddr] <= r_sample;
        end
        r_rd0 <= r_row_lines[w_raddr0];
        r_rd1 <= r_row_lines[w_raddr1];
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_user;

endmodule

@@ rtl/hnmg_checker.sv @@
// ----------------------------------------------------------------------------
// hnmg_checker
// port level checks of the normal map generator, bound to the top level
// ----------------------------------------------------------------------------
module hnmg_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    // normal_x, normal_y, normal_z, pixel_column, pixel_row, zero fill
    input logic [hnmg_pkg::O_DATA_W-1:0]   m_axis_tdata,
    input logic                            m_axis_tlast,   // run_last
    input logic                            m_axis_tuser    // image_last
);
    import hnmg_pkg::*;

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    a_out_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // the final pixel of an image is always the last result of its item
    a_image_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("image end without run end");

    // one item at a time: no accept in the cycle after an accept
    a_one_item_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

    a_reset_empties_output: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind heightmap_normal_map_generator_unit hnmg_checker u_hnmg_checker (.*);

@@ sim/heightmap_normal_map_generator_unit_test.sv @@
// ----------------------------------------------------------------------------
// heightmap_normal_map_generator_unit_test
// streams height maps of many sizes through the normal map generator, predicts
// every normal vector with a bit-exact integer model and compares each result
// item in order, with bursty input, a stalling output and one long output hold
// ----------------------------------------------------------------------------
module heightmap_normal_map_generator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hnmg_pkg::*;

    localparam int    RESET_CYCLES = 9;
    localparam int    RANDOM_ITEMS = 180;
    localparam int    SETTLE_CYCLES = 200;
    localparam int    HOLD_CYCLES = 3000;
    localparam int    HOLD_AFTER = 60;
    localparam time   RUN_LIMIT = 10_000_000;

    typedef enum int {
        PAT_NOISE,
        PAT_FLAT,
        PAT_EXTREME,
        PAT_RAMP
    } t_pattern;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    typedef struct packed {
        logic [N_W-1:0]   nx;
        logic [N_W-1:0]   ny;
        logic [N_W-1:0]   nz;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             run_last;
        logic             image_last;
    } t_normal;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [I_DATA_W-1:0]   s_axis_tdata = '0;    // height_sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // normal_x, normal_y, normal_z, pixel_column, pixel_row, zero fill
    logic [O_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tlast;          // run_last
    logic                  m_axis_tuser;          // image_last
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // predictor state
    logic [H_W-1:0]     line_mem [LINE_DEPTH];
    int unsigned        col_cnt = 0;
    int unsigned        row_cnt = 0;
    int unsigned        rotation = 0;
    logic [DIM_W-1:0]   cfg_width = RST_IMAGE_WIDTH;
    logic [DIM_W-1:0]   cfg_height = RST_IMAGE_HEIGHT;
    logic [SHARP_W-1:0] cfg_sharp = RST_SHARPNESS;

    logic [H_W-1:0] height_queue [$];
    t_normal        normal_due [$];
    int             errors = 0;
    int             items_in = 0;
    bit             in_taken = 1'b0;
    bit             hold_rx = 1'b0;
    int             burst_left = 0;
    int             gap_left = 0;
    t_rx_mode       rx_mode = RX_OPEN;
    int             rx_left = 0;

    heightmap_normal_map_generator_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned top);
        int unsigned d;
        d = (v == 0) ? 1 : v;
        return (d > top) ? top : d;
    endfunction

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'h1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // [-1,1] to unsigned q0.16, halves rounded away from zero
    function automatic logic [N_W-1:0] to_unit(longint a, longint unsigned len);
        longint unsigned mag;
        longint unsigned t;
        longint unsigned r;
        mag = (a < 0) ? -a : a;
        t = (65536 * mag + len) / (2 * len);
        r = (a < 0) ? 32768 - t : 32768 + t;
        return (r > 65535) ? 16'hFFFF : r[N_W-1:0];
    endfunction

    function automatic t_normal make_normal(longint left, longint right, longint above,
                                            longint below, int unsigned col,
                                            int unsigned row, logic img_end);
        longint          x;
        longint          y;
        longint          z;
        longint unsigned s;
        longint unsigned len;
        t_normal         n;
        x = X_SCALE * (left - right);
        z = X_SCALE * (above - below);
        y = longint'(cfg_sharp) << Y_SHIFT;
        s = x * x + y * y + z * z;
        if (s == 0) begin
            n.nx = HALF;
            n.ny = HALF;
            n.nz = HALF;
        end else begin
            len = int_root(s);
            n.nx = to_unit(x, len);
            n.ny = to_unit(y, len);
            n.nz = to_unit(z, len);
        end
        n.col = col[POS_W-1:0];
        n.row = row[POS_W-1:0];
        n.run_last = 1'b0;
        n.image_last = img_end;
        return n;
    endfunction

    function automatic longint line_at(int unsigned line, int unsigned col);
        return longint'(line_mem[line * MAX_WIDTH + col]);
    endfunction

    task automatic predict_normals(logic [H_W-1:0] sample);
        int unsigned w, h, c, r, wl, cur, prv, prv2, x, up;
        t_normal     found [3];
        int          n;
        w = clamp_dim(cfg_width, MAX_WIDTH);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        if (col_cnt > w - 1) col_cnt = w - 1;
        if (row_cnt > h - 1) row_cnt = h - 1;
        c = col_cnt;
        r = row_cnt;
        wl = w - 1;
        cur = rotation % 3;
        prv = (cur + 2) % 3;
        prv2 = (cur + 1) % 3;
        n = 0;
        line_mem[cur * MAX_WIDTH + c] = sample;

        // pixel of the row above, now that its lower neighbor has come
        if (r >= 1) begin
            up = (r >= 2) ? prv2 : prv;
            found[n] = make_normal(line_at(prv, (c > 0) ? c - 1 : 0),
                                   line_at(prv, (c < wl) ? c + 1 : wl),
                                   line_at(up, c), line_at(cur, c), c, r - 1, 1'b0);
            n++;
        end
        // bottom row flushes one column behind
        if (r == h - 1 && c >= 1) begin
            x = c - 1;
            up = (r >= 1) ? prv : cur;
            found[n] = make_normal(line_at(cur, (x > 0) ? x - 1 : 0), line_at(cur, c),
                                   line_at(up, x), line_at(cur, x), x, r, 1'b0);
            n++;
        end
        if (r == h - 1 && c == wl) begin
            up = (r >= 1) ? prv : cur;
            found[n] = make_normal(line_at(cur, (c > 0) ? c - 1 : 0), line_at(cur, c),
                                   line_at(up, c), line_at(cur, c), c, r, 1'b1);
            n++;
        end
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) found[i].run_last = 1'b1;
            normal_due = {normal_due, found[i]};
        end

        if (c >= wl) begin
            col_cnt = 0;
            if (r >= h - 1) begin
                row_cnt = 0;
                rotation = 0;
            end else begin
                row_cnt = r + 1;
                rotation = (cur + 1) % 3;
            end
        end else begin
            col_cnt = c + 1;
        end
    endtask

    function automatic string show(t_normal n);
        return $sformatf("x=%h y=%h z=%h col=%0d row=%0d last=%b end=%b",
                         n.nx, n.ny, n.nz, n.col, n.row, n.run_last, n.image_last);
    endfunction

    task automatic flag_error(string msg);
        $display("ERROR %0t ns: %s", $realtime, msg);
        errors++;
    endtask

    // monitor: configuration copy, result check, input prediction
    always @(posedge i_clk) begin
        t_normal got;
        t_normal want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  cfg_width = i_cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT: cfg_height = i_cfg_data[DIM_W-1:0];
                    CFG_SHARPNESS:    cfg_sharp = i_cfg_data[SHARP_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.nx = m_axis_tdata[15:0];
                got.ny = m_axis_tdata[31:16];
                got.nz = m_axis_tdata[47:32];
                got.col = m_axis_tdata[57:48];
                got.row = m_axis_tdata[67:58];
                got.run_last = m_axis_tlast;
                got.image_last = m_axis_tuser;
                if (normal_due.size() == 0) begin
                    flag_error({"result with nothing pending: ", show(got)});
                end else begin
                    want = normal_due.pop_front();
                    if (got !== want)
                        flag_error({"got ", show(got), " want ", show(want)});
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_normals(s_axis_tdata);
                void'(height_queue.pop_front());
                in_taken = 1'b1;
                items_in++;
            end
        end
    end

    // sender: bursts of random length, gaps only after an item is taken
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || in_taken) begin
            in_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (height_queue.size() > 0) begin
                if (burst_left == 0) burst_left = $urandom_range(1, 16);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= height_queue[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: picks a random stall pattern and changes it after a random interval
    always @(negedge i_clk) begin
        bit ready;
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:     ready = 1'b1;
            RX_COIN:     ready = ($urandom_range(0, 1) == 1);
            RX_PERIODIC: ready = (rx_left % 4 == 0);
            default:     ready = ($urandom_range(0, 7) == 0);
        endcase
        m_axis_tready <= ready && !hold_rx;
    end

    // long output hold so the block backs up and stalls its input
    initial begin
        while (items_in < HOLD_AFTER || height_queue.size() < 3)
            @(negedge i_clk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_rx = 1'b0;
    end

    initial begin
        #RUN_LIMIT;
        $display("heightmap_normal_map_generator_unit: mismatch");
        $finish;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_image(int w, int h, int sharp);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_SHARPNESS, sharp);
    endtask

    task automatic wait_idle();
        while (height_queue.size() != 0 || normal_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_height(logic [H_W-1:0] v);
        height_queue = {height_queue, v};
    endtask

    task automatic push_heights(int count, t_pattern pat);
        logic [H_W-1:0] v;
        v = 16'($urandom);
        repeat (count) begin
            case (pat)
                PAT_NOISE:   v = 16'($urandom);
                PAT_FLAT:    ;
                PAT_EXTREME: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default:     v = v + 16'($urandom_range(0, 128)) - 16'd64;
            endcase
            queue_height(v);
        end
    endtask

    // samples left in the current image, valid only while idle
    function automatic int samples_to_end();
        int unsigned w, h, cc, rc;
        w = clamp_dim(cfg_width, MAX_WIDTH);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        cc = (col_cnt > w - 1) ? w - 1 : col_cnt;
        rc = (row_cnt > h - 1) ? h - 1 : row_cnt;
        return (h - 1 - rc) * w + (w - cc);
    endfunction

    function automatic int pick_sharpness();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 65535;
            2:       return $urandom_range(1, 50);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    initial begin
        logic [H_W-1:0] corner [6];
        int             w;
        int             h;
        int             k;
        int             random_items;
        t_pattern       pat;
        corner = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
        random_items = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // flat single row with no vertical part: zero vector everywhere
        set_image(3, 1, 0);
        repeat (3) queue_height(16'h0000);
        wait_idle();

        // single pixel image, steepest sharpness
        set_image(1, 1, 65535);
        queue_height(16'hFFFF);
        wait_idle();

        // full-scale steps with flat y: components saturate at both ends
        set_image(2, 3, 0);
        foreach (corner[i]) queue_height(corner[i]);
        wait_idle();

        // widest row, then width shrinks below the column counter
        set_image(MAX_WIDTH, 1, 1000);
        push_heights(4, PAT_NOISE);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 2);
        push_heights(samples_to_end(), PAT_NOISE);
        wait_idle();

        // tallest image, then height shrinks below the row counter
        set_image(2, MAX_HEIGHT, 12345);
        push_heights(8, PAT_RAMP);
        wait_idle();
        write_reg(CFG_IMAGE_HEIGHT, 2);
        push_heights(samples_to_end(), PAT_RAMP);
        wait_idle();

        while (random_items < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            pat = t_pattern'($urandom_range(0, 3));
            set_image(w, h, pick_sharpness());
            if ($urandom_range(0, 4) == 0 && w * h > 1) begin
                k = $urandom_range(1, w * h - 1);
                push_heights(k, pat);
                random_items += k;
                wait_idle();
                // only shrink mid-image so every line entry read was written
                write_reg(CFG_IMAGE_WIDTH, $urandom_range(1, w));
                write_reg(CFG_IMAGE_HEIGHT, $urandom_range(1, h));
                if ($urandom_range(0, 1)) write_reg(CFG_SHARPNESS, pick_sharpness());
            end
            k = samples_to_end();
            push_heights(k, pat);
            random_items += k;
            wait_idle();
        end

        if (errors == 0) begin
            $display("heightmap_normal_map_generator_unit: match");
        end else begin
            $display("heightmap_normal_map_generator_unit: mismatch");
        end
        $finish;
    end

endmodule
